[design/irdec_pkg.sv]
// ----------------------------------------------------------------------------
// IR remote decoder package
// Shared types, register indexes, reset values and the button code table.
// ----------------------------------------------------------------------------
package irdec_pkg;

	typedef enum logic [1:0] {
		CMD_PULSE = 2'd0,
		CMD_END   = 2'd1,
		CMD_POLL  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_SHORT      = 3'd0,
		ST_KNOWN      = 3'd1,
		ST_UNKNOWN    = 3'd2,
		ST_BAD_HEADER = 3'd3,
		ST_POLL       = 3'd4
	} status_t;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;
	localparam int NUM_BUTTONS    = 7;
	localparam int TIME_BITS      = 32;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_HEADER_FIRST    = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_HEADER_SECOND   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_TIMEOUT_MS = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ZERO_RATIO_LOW  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ZERO_RATIO_HIGH = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ONE_RATIO_LOW   = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ONE_RATIO_HIGH  = 3'd6;

	localparam logic [7:0]  RST_HEADER_FIRST    = 8'hEE;
	localparam logic [7:0]  RST_HEADER_SECOND   = 8'h87;
	localparam logic [15:0] RST_HOLD_TIMEOUT_MS = 16'd300;
	localparam logic [7:0]  RST_ZERO_RATIO_LOW  = 8'd7;
	localparam logic [7:0]  RST_ZERO_RATIO_HIGH = 8'd13;
	localparam logic [7:0]  RST_ONE_RATIO_LOW   = 8'd21;
	localparam logic [7:0]  RST_ONE_RATIO_HIGH  = 8'd36;

	localparam logic [7:0] BTN_ENTER = 8'h5D;
	localparam logic [7:0] BTN_LEFT  = 8'h08;
	localparam logic [7:0] BTN_RIGHT = 8'h07;
	localparam logic [7:0] BTN_UP    = 8'h0B;
	localparam logic [7:0] BTN_DOWN  = 8'h0D;
	localparam logic [7:0] BTN_MENU  = 8'h02;
	localparam logic [7:0] BTN_PLAY  = 8'h5E;

	localparam logic [3:0] TENTHS_SCALE = 4'd10;

	typedef struct packed {
		logic [7:0]  header_first;
		logic [7:0]  header_second;
		logic [15:0] hold_timeout_ms;
		logic [7:0]  zero_ratio_low;
		logic [7:0]  zero_ratio_high;
		logic [7:0]  one_ratio_low;
		logic [7:0]  one_ratio_high;
	} cfg_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic                 bit_ok;
		logic                 bit_val;
		logic [TIME_BITS-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [NUM_BUTTONS-1:0] flags;
		logic                   held;
		status_t                status;
	} result_t;

	function automatic logic [NUM_BUTTONS-1:0] button_onehot(input logic [7:0] code);
		logic [NUM_BUTTONS-1:0] hot;
		hot = '0;
		case (code)
			BTN_ENTER: hot = 7'b0000001;
			BTN_LEFT:  hot = 7'b0000010;
			BTN_RIGHT: hot = 7'b0000100;
			BTN_UP:    hot = 7'b0001000;
			BTN_DOWN:  hot = 7'b0010000;
			BTN_MENU:  hot = 7'b0100000;
			BTN_PLAY:  hot = 7'b1000000;
			default:   hot = '0;
		endcase
		return hot;
	endfunction

endpackage

[design/irdec_fifo.sv]
// ----------------------------------------------------------------------------
// IR remote decoder queue
// Small first-in first-out buffer; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module irdec_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wr_ptr_q;
	logic [AW:0]      rd_ptr_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (wr_ptr_q == rd_ptr_q);
	assign full    = (wr_ptr_q[AW] != rd_ptr_q[AW]) && (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q[AW-1:0]] <= wdata;
		end
	end

endmodule

[design/irdec_front.sv]
// ----------------------------------------------------------------------------
// IR remote decoder front end
// Accepts items, classifies pulse ratios into bit 0, bit 1 or invalid.
// ----------------------------------------------------------------------------
module irdec_front #(
	parameter int DURATION_BITS = 15
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [1:0]                command,
	input  logic [DURATION_BITS-1:0]  mark_duration,
	input  logic [DURATION_BITS-1:0]  space_duration,
	input  logic [31:0]               now_ms,
	input  irdec_pkg::cfg_t           cfg,
	output logic                      q_push,
	output irdec_pkg::item_t          q_item,
	input  logic                      q_full
);

	localparam int PW = DURATION_BITS + 8;

	irdec_pkg::cmd_t  cmd_in;
	irdec_pkg::item_t item_d;
	irdec_pkg::item_t item_s1;
	logic             valid_s1;
	logic             advance;
	logic [PW-1:0]    space_x10;
	logic [PW-1:0]    zero_lo;
	logic [PW-1:0]    zero_hi;
	logic [PW-1:0]    one_lo;
	logic [PW-1:0]    one_hi;
	logic             mark_nz;
	logic             in_zero;
	logic             in_one;

	assign cmd_in    = irdec_pkg::cmd_t'(command);
	assign space_x10 = PW'(space_duration) * PW'(irdec_pkg::TENTHS_SCALE);
	assign zero_lo   = PW'(mark_duration) * PW'(cfg.zero_ratio_low);
	assign zero_hi   = PW'(mark_duration) * PW'(cfg.zero_ratio_high);
	assign one_lo    = PW'(mark_duration) * PW'(cfg.one_ratio_low);
	assign one_hi    = PW'(mark_duration) * PW'(cfg.one_ratio_high);
	assign mark_nz   = |mark_duration;
	assign in_zero   = mark_nz && (space_x10 >= zero_lo) && (space_x10 <= zero_hi);
	assign in_one    = mark_nz && (space_x10 >= one_lo) && (space_x10 <= one_hi);

	always_comb begin
		item_d.cmd     = cmd_in;
		item_d.bit_ok  = in_zero || in_one;
		item_d.bit_val = !in_zero;
		item_d.now_ms  = now_ms;
	end

	assign advance = !valid_s1 || !q_full;
	assign full    = !advance;
	assign q_push  = valid_s1;
	assign q_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push && (cmd_in != irdec_pkg::CMD_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push) begin
			item_s1 <= item_d;
		end
	end

endmodule

[design/irdec_back.sv]
// ----------------------------------------------------------------------------
// IR remote decoder back end
// Assembles frame bytes, latches button flags and applies the hold timeout.
// ----------------------------------------------------------------------------
module irdec_back (
	input  logic               clk,
	input  logic               arst_n,
	input  irdec_pkg::cfg_t    cfg,
	input  irdec_pkg::item_t   q_item,
	input  logic               q_empty,
	output logic               q_pop,
	output logic               out_push,
	output irdec_pkg::result_t out_item,
	input  logic               out_full
);

	logic [7:0]                        pulse_index_q;
	logic [7:0]                        pulse_index_d;
	logic [7:0]                        asm_q;
	logic [7:0]                        asm_d;
	logic [7:0]                        asm_base;
	logic [2:0]                        bytes_seen_q;
	logic [2:0]                        bytes_seen_d;
	logic [7:0]                        frame_q [3];
	logic [7:0]                        frame_d [3];
	logic [irdec_pkg::NUM_BUTTONS-1:0] flags_q;
	logic [irdec_pkg::NUM_BUTTONS-1:0] flags_d;
	logic                              recv_q;
	logic                              recv_d;
	logic [31:0]                       last_q;
	logic [31:0]                       last_d;
	logic [31:0]                       elapsed;
	logic [2:0]                        pos;
	logic [irdec_pkg::NUM_BUTTONS-1:0] button;
	irdec_pkg::status_t                status;
	logic                              needs_result;
	logic                              fire;

	assign needs_result = (q_item.cmd != irdec_pkg::CMD_PULSE);
	assign fire         = !q_empty && (!needs_result || !out_full);
	assign q_pop        = fire;
	assign out_push     = fire && needs_result;
	assign pos          = pulse_index_q[2:0] - 3'd1;
	assign button       = irdec_pkg::button_onehot(frame_q[2]);
	assign asm_base     = (pos == 3'd0) ? 8'd0 : asm_q;
	assign elapsed      = q_item.now_ms - last_d;

	always_comb begin
		pulse_index_d = pulse_index_q;
		asm_d         = asm_q;
		bytes_seen_d  = bytes_seen_q;
		frame_d       = frame_q;
		flags_d       = flags_q;
		recv_d        = recv_q;
		last_d        = last_q;
		status        = irdec_pkg::ST_POLL;
		case (q_item.cmd)
			irdec_pkg::CMD_PULSE: begin
				if (pulse_index_q != 8'hFF) begin
					if (pulse_index_q != 8'd0) begin
						asm_d = asm_base;
						if (q_item.bit_ok) begin
							asm_d = asm_base | (8'(q_item.bit_val) << pos);
							if (pos == 3'd7) begin
								if (bytes_seen_q < 3'd3) begin
									frame_d[bytes_seen_q[1:0]] = asm_d;
								end
								if (bytes_seen_q != 3'd7) begin
									bytes_seen_d = bytes_seen_q + 3'd1;
								end
							end
						end
					end
					pulse_index_d = pulse_index_q + 8'd1;
				end
			end
			irdec_pkg::CMD_END: begin
				if (bytes_seen_q < 3'd4) begin
					status = irdec_pkg::ST_SHORT;
				end else if (frame_q[0] == cfg.header_first &&
						frame_q[1] == cfg.header_second) begin
					recv_d = 1'b1;
					last_d = q_item.now_ms;
					if (|button) begin
						flags_d = flags_q | button;
						status  = irdec_pkg::ST_KNOWN;
					end else begin
						status = irdec_pkg::ST_UNKNOWN;
					end
				end else begin
					status = irdec_pkg::ST_BAD_HEADER;
				end
				pulse_index_d = '0;
				asm_d         = '0;
				bytes_seen_d  = '0;
				frame_d       = '{default: '0};
			end
			irdec_pkg::CMD_POLL: begin
				recv_d = 1'b0;
				status = irdec_pkg::ST_POLL;
			end
			default: begin
			end
		endcase
		if (needs_result && recv_d && (elapsed > {16'd0, cfg.hold_timeout_ms})) begin
			recv_d  = 1'b0;
			flags_d = '0;
		end
	end

	always_comb begin
		out_item.flags  = flags_d;
		out_item.held   = recv_d;
		out_item.status = status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_index_q <= '0;
			asm_q         <= '0;
			bytes_seen_q  <= '0;
			frame_q       <= '{default: '0};
			flags_q       <= '0;
			recv_q        <= 1'b0;
			last_q        <= '0;
		end else if (fire) begin
			pulse_index_q <= pulse_index_d;
			asm_q         <= asm_d;
			bytes_seen_q  <= bytes_seen_d;
			frame_q       <= frame_d;
			flags_q       <= flags_d;
			recv_q        <= recv_d;
			last_q        <= last_d;
		end
	end

endmodule

[design/ir_remote_pulse_decoder.sv]
// An item is registered in the front stage, then in the middle queue; the back end
// writes its result into the output queue. Throughput: one item per cycle while no queue
// is full. The back end stalls on end and poll items when the output queue is full.
// Reset: arst_n clears all queues, frame state, flags and receive stamp at once,
// and restores every configuration register to its default.
// ----------------------------------------------------------------------------
// IR remote pulse decoder
// Decodes pulse pairs into frame bytes and button flags behind two queues.
// ----------------------------------------------------------------------------
module ir_remote_pulse_decoder #(
	parameter int DURATION_BITS = 15
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [1:0]               command,
	input  logic [DURATION_BITS-1:0] mark_duration,
	input  logic [DURATION_BITS-1:0] space_duration,
	input  logic [31:0]              now_ms,
	output logic                     empty,
	input  logic                     pop,
	output logic                     enter_pressed,
	output logic                     left_pressed,
	output logic                     right_pressed,
	output logic                     up_pressed,
	output logic                     down_pressed,
	output logic                     menu_pressed,
	output logic                     play_pressed,
	output logic                     frame_held,
	output logic [2:0]               frame_status,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [2:0]               cfg_index,
	input  logic [15:0]              cfg_data
);

	irdec_pkg::cfg_t    cfg_q;
	logic               mid_push;
	irdec_pkg::item_t   mid_wdata;
	logic               mid_full;
	logic               mid_pop;
	irdec_pkg::item_t   mid_rdata;
	logic               mid_empty;
	logic               res_push;
	irdec_pkg::result_t res_wdata;
	logic               res_full;
	irdec_pkg::result_t res_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first    <= irdec_pkg::RST_HEADER_FIRST;
			cfg_q.header_second   <= irdec_pkg::RST_HEADER_SECOND;
			cfg_q.hold_timeout_ms <= irdec_pkg::RST_HOLD_TIMEOUT_MS;
			cfg_q.zero_ratio_low  <= irdec_pkg::RST_ZERO_RATIO_LOW;
			cfg_q.zero_ratio_high <= irdec_pkg::RST_ZERO_RATIO_HIGH;
			cfg_q.one_ratio_low   <= irdec_pkg::RST_ONE_RATIO_LOW;
			cfg_q.one_ratio_high  <= irdec_pkg::RST_ONE_RATIO_HIGH;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				irdec_pkg::CFG_HEADER_FIRST:    cfg_q.header_first    <= cfg_data[7:0];
				irdec_pkg::CFG_HEADER_SECOND:   cfg_q.header_second   <= cfg_data[7:0];
				irdec_pkg::CFG_HOLD_TIMEOUT_MS: cfg_q.hold_timeout_ms <= cfg_data;
				irdec_pkg::CFG_ZERO_RATIO_LOW:  cfg_q.zero_ratio_low  <= cfg_data[7:0];
				irdec_pkg::CFG_ZERO_RATIO_HIGH: cfg_q.zero_ratio_high <= cfg_data[7:0];
				irdec_pkg::CFG_ONE_RATIO_LOW:   cfg_q.one_ratio_low   <= cfg_data[7:0];
				irdec_pkg::CFG_ONE_RATIO_HIGH:  cfg_q.one_ratio_high  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	irdec_front #(
		.DURATION_BITS(DURATION_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.command        (command),
		.mark_duration  (mark_duration),
		.space_duration (space_duration),
		.now_ms         (now_ms),
		.cfg            (cfg_q),
		.q_push         (mid_push),
		.q_item         (mid_wdata),
		.q_full         (mid_full)
	);

	irdec_fifo #(
		.WIDTH($bits(irdec_pkg::item_t)),
		.DEPTH(2)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	irdec_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_item   (mid_rdata),
		.q_empty  (mid_empty),
		.q_pop    (mid_pop),
		.out_push (res_push),
		.out_item (res_wdata),
		.out_full (res_full)
	);

	irdec_fifo #(
		.WIDTH($bits(irdec_pkg::result_t)),
		.DEPTH(2)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign enter_pressed = res_rdata.flags[0];
	assign left_pressed  = res_rdata.flags[1];
	assign right_pressed = res_rdata.flags[2];
	assign up_pressed    = res_rdata.flags[3];
	assign down_pressed  = res_rdata.flags[4];
	assign menu_pressed  = res_rdata.flags[5];
	assign play_pressed  = res_rdata.flags[6];
	assign frame_held    = res_rdata.held;
	assign frame_status  = res_rdata.status;

endmodule

[design/irdec_checker.sv]
// ----------------------------------------------------------------------------
// IR remote decoder checker
// Port-level properties of the result queue, bound to the top level.
// ----------------------------------------------------------------------------
module irdec_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic       enter_pressed,
	input logic       left_pressed,
	input logic       right_pressed,
	input logic       up_pressed,
	input logic       down_pressed,
	input logic       menu_pressed,
	input logic       play_pressed,
	input logic       frame_held,
	input logic [2:0] frame_status
);

	logic [6:0] flags;

	assign flags = {play_pressed, menu_pressed, down_pressed, up_pressed,
		right_pressed, left_pressed, enter_pressed};

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(flags) && $stable(frame_held) &&
		$stable(frame_status)))
		else $error("waiting result changed before transfer");

	a_poll_drops_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_status == 3'(irdec_pkg::ST_POLL)) |-> !frame_held)
		else $error("poll result still shows a held frame");

	a_known_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_status == 3'(irdec_pkg::ST_KNOWN)) |->
		(frame_held && $countones(flags) >= 1))
		else $error("known command without held frame or button flag");

	a_unknown_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_status == 3'(irdec_pkg::ST_UNKNOWN)) |-> frame_held)
		else $error("unknown command result without held frame");

endmodule

bind ir_remote_pulse_decoder irdec_checker u_irdec_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.empty         (empty),
	.pop           (pop),
	.enter_pressed (enter_pressed),
	.left_pressed  (left_pressed),
	.right_pressed (right_pressed),
	.up_pressed    (up_pressed),
	.down_pressed  (down_pressed),
	.menu_pressed  (menu_pressed),
	.play_pressed  (play_pressed),
	.frame_held    (frame_held),
	.frame_status  (frame_status)
);
